### design/iol_pkg.sv
// Package for the indexed ordered list: field widths, operation and status codes,
// controller states and the controller-to-datapath command group. No dependencies.
`timescale 1ns / 1ps

package iol_pkg;

	localparam int FUNC_W  = 2;
	localparam int POS_W   = 5;
	localparam int VALUE_W = 32;
	localparam int STS_W   = 2;
	localparam int FOUND_W = 4;
	localparam int COUNT_W = 5;

	localparam int DEF_DEPTH     = 16;
	localparam int DEF_ELEM_BITS = 32;

	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_READ   = 2'd1;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;
	localparam logic [FUNC_W-1:0] FN_FIND   = 2'd3;

	localparam logic [STS_W-1:0] STS_OK      = 2'd0;
	localparam logic [STS_W-1:0] STS_BAD_POS = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL_NF = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_FIND,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic find;
	} cmd_t;

endpackage

### design/iol_if.sv
// Request and response channel interfaces of the indexed ordered list.
// Depends on iol_pkg for the field widths.
`timescale 1ns / 1ps

interface iol_req_if;
	logic                           valid;
	logic                           ready;
	logic [iol_pkg::FUNC_W-1:0]     func;
	logic [iol_pkg::POS_W-1:0]      position;
	logic [iol_pkg::VALUE_W-1:0]    value;

	modport source (output valid, output func, output position, output value, input ready);
	modport sink (input valid, input func, input position, input value, output ready);
endinterface

interface iol_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [iol_pkg::STS_W-1:0]      status;
	logic [iol_pkg::VALUE_W-1:0]    read_value;
	logic [iol_pkg::FOUND_W-1:0]    found_position;
	logic [iol_pkg::COUNT_W-1:0]    entry_count;

	modport source (output valid, output status, output read_value, output found_position,
		output entry_count, input ready);
	modport sink (input valid, input status, input read_value, input found_position,
		input entry_count, output ready);
endinterface

### design/iol_ctrl.sv
// Controller of the indexed ordered list: sequences each item through
// evaluate, search and response. Depends on iol_pkg.
`timescale 1ns / 1ps

module iol_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output iol_pkg::cmd_t cmd
);
	import iol_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_EVAL;
			end
			ST_EVAL: state_nxt = ST_FIND;
			ST_FIND: state_nxt = ST_DONE;
			ST_DONE: begin
				if (out_ready) state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EVAL: cmd.eval = 1'b1;
			ST_FIND: cmd.find = 1'b1;
			ST_DONE: out_valid = 1'b1;
		endcase
	end

	// An accepted item is always evaluated in the following cycle.
	a_load_then_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> cmd.eval)
		else $error("accepted item was not evaluated");

	// The search step only ever follows the evaluate step.
	a_find_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.find |-> $past(cmd.eval))
		else $error("search step without a preceding evaluate step");

	// No new item is taken while a result is on offer.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while a result is pending");

endmodule

### design/iol_dpath.sv
// Datapath of the indexed ordered list: a row of element cells that shift up
// or down in place, per-cell compare, the first-match search and result registers.
// Depends on iol_pkg; driven by commands from iol_ctrl.
`timescale 1ns / 1ps

module iol_dpath #(
	parameter int DEPTH     = iol_pkg::DEF_DEPTH,
	parameter int ELEM_BITS = iol_pkg::DEF_ELEM_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  iol_pkg::cmd_t                cmd,
	input  logic [iol_pkg::FUNC_W-1:0]   func,
	input  logic [iol_pkg::POS_W-1:0]    position,
	input  logic [iol_pkg::VALUE_W-1:0]  value,
	output logic [iol_pkg::STS_W-1:0]    status,
	output logic [iol_pkg::VALUE_W-1:0]  read_value,
	output logic [iol_pkg::FOUND_W-1:0]  found_position,
	output logic [iol_pkg::COUNT_W-1:0]  entry_count
);
	import iol_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [FUNC_W-1:0]    op_q;
	logic [POS_W-1:0]     pos_q;
	logic [ELEM_BITS-1:0] val_q;
	logic [ELEM_BITS-1:0] cells_q [DEPTH];
	logic [CNT_W-1:0]     count_q;
	logic [DEPTH-1:0]     match_q;
	logic [STS_W-1:0]     status_q;
	logic [ELEM_BITS-1:0] rdata_q;
	logic [IDX_W-1:0]     found_q;

	logic [ELEM_BITS+VALUE_W-1:0] val_wide;
	logic [ELEM_BITS+VALUE_W-1:0] rd_wide;
	logic [IDX_W+FOUND_W-1:0]     found_wide;
	logic [CNT_W+COUNT_W-1:0]     cnt_wide;
	logic [CMP_W-1:0]             pos_e;
	logic [CMP_W-1:0]             cnt_e;
	logic [IDX_W-1:0]             rd_idx;
	logic                         ins_ok;
	logic                         acc_ok;
	logic                         do_ins;
	logic                         do_rem;
	logic                         hit;
	logic [IDX_W-1:0]             hit_idx;

	assign val_wide = {{ELEM_BITS{1'b0}}, value};
	assign pos_e    = CMP_W'(pos_q);
	assign cnt_e    = CMP_W'(count_q);
	assign rd_idx   = IDX_W'(pos_q);
	// An insert may land anywhere up to and including the current end.
	assign ins_ok   = (pos_e <= cnt_e) && (cnt_e < CMP_W'(DEPTH));
	assign acc_ok   = pos_e < cnt_e;
	assign do_ins   = cmd.eval && (op_q == FN_INSERT) && ins_ok;
	assign do_rem   = cmd.eval && (op_q == FN_REMOVE) && acc_ok;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= func;
			pos_q <= position;
			val_q <= val_wide[ELEM_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_ins) begin
			count_q <= count_q + 1'b1;
		end else if (do_rem) begin
			count_q <= count_q - 1'b1;
		end
	end

	// Each cell only ever takes the new value or one of its two neighbors.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (do_ins) begin
				if (CMP_W'(i) == pos_e) begin
					cells_q[i] <= val_q;
				end else if (CMP_W'(i) > pos_e) begin
					if (i > 0) cells_q[i] <= cells_q[(i > 0) ? i - 1 : 0];
				end
			end else if (do_rem) begin
				if ((CMP_W'(i) >= pos_e) && (i < DEPTH - 1)) begin
					cells_q[i] <= cells_q[(i < DEPTH - 1) ? i + 1 : i];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.eval) begin
				match_q[i] <= (cells_q[i] == val_q) && (CMP_W'(i) < cnt_e);
			end
		end
	end

	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			found_q <= '0;
			rdata_q <= '0;
			status_q <= STS_OK;
			unique case (op_q)
				FN_INSERT: begin
					if (pos_e > cnt_e) status_q <= STS_BAD_POS;
					else if (!ins_ok) status_q <= STS_FULL_NF;
				end
				FN_READ, FN_REMOVE: begin
					if (acc_ok) rdata_q <= cells_q[rd_idx];
					else status_q <= STS_BAD_POS;
				end
				FN_FIND: ;
			endcase
		end else if (cmd.find && (op_q == FN_FIND)) begin
			status_q <= hit ? STS_OK : STS_FULL_NF;
			found_q  <= hit ? hit_idx : '0;
		end
	end

	assign rd_wide        = {{VALUE_W{1'b0}}, rdata_q};
	assign found_wide     = {{FOUND_W{1'b0}}, found_q};
	assign cnt_wide       = {{COUNT_W{1'b0}}, count_q};
	assign status         = status_q;
	assign read_value     = rd_wide[VALUE_W-1:0];
	assign found_position = found_wide[FOUND_W-1:0];
	assign entry_count    = cnt_wide[COUNT_W-1:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(DEPTH))
		else $error("entry count beyond list depth");

	// The count moves only in the evaluate step.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.eval |=> $stable(count_q))
		else $error("entry count changed outside the evaluate step");

	// A shift up only happens while there is a free cell at the top.
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |-> (cnt_e < CMP_W'(DEPTH)))
		else $error("insert into a full list");

endmodule

### design/indexed_ordered_list.sv
// Top level of the indexed ordered list: joins controller and datapath to
// the request and response channels. Depends on iol_pkg, iol_if, iol_ctrl, iol_dpath.
//
//   channel  direction  payload
//   req      in         func, position, value
//   rsp      out        status, read_value, found_position, entry_count
//
// From acceptance to the next acceptance, with rsp taken at once, an item runs
// through: accept, evaluate (cells shift, compare against all cells),
// first-match search over the compare vector, then the result is offered.
// The controller takes one item at a time; req.ready is high only while idle.
// A stall on rsp holds the result and keeps req.ready low until it is taken.
// Reset clears the entry count; cell contents need no clearing.
`timescale 1ns / 1ps

module indexed_ordered_list #(
	parameter int DEPTH     = iol_pkg::DEF_DEPTH,
	parameter int ELEM_BITS = iol_pkg::DEF_ELEM_BITS
) (
	input  logic  clk,
	input  logic  arst_n,
	iol_req_if.sink   req,
	iol_rsp_if.source rsp
);
	import iol_pkg::*;

	cmd_t cmd;

	iol_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	iol_dpath #(
		.DEPTH     (DEPTH),
		.ELEM_BITS (ELEM_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.func           (req.func),
		.position       (req.position),
		.value          (req.value),
		.status         (rsp.status),
		.read_value     (rsp.read_value),
		.found_position (rsp.found_position),
		.entry_count    (rsp.entry_count)
	);

endmodule
